// ===== design/ioct_pkg.sv =====
// Package for the in-order reserve/commit tracker.
// Holds widths, command/error/outcome codes and the stage, state and result structs.
// No dependencies; every other design file imports it.
`default_nettype none

package ioct_pkg;

    // Width of the tracking counters; they wrap at this width.
    localparam int COUNT_WIDTH = 16;
    // Width of the id, ordinal and count fields on the ports.
    localparam int FIELD_WIDTH = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [FIELD_WIDTH-1:0] field_t;

    typedef enum logic [2:0] {
        CMD_START           = 3'd0,
        CMD_RESERVE         = 3'd1,
        CMD_RENDER          = 3'd2,
        CMD_COMMIT          = 3'd3,
        CMD_CLOSE_PLANNED   = 3'd4,
        CMD_CLOSE_UNPLANNED = 3'd5
    } cmd_code_t;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_INVALID        = 3'd1,
        ERR_NOT_STARTED    = 3'd2,
        ERR_CLOSED         = 3'd3,
        ERR_MISMATCH       = 3'd4,
        ERR_RENDER_MISSING = 3'd5,
        ERR_DUP_RENDER     = 3'd6,
        ERR_CONSERVATION   = 3'd7
    } err_code_t;

    typedef enum logic [1:0] {
        OUT_NONE      = 2'd0,
        OUT_RESERVED  = 2'd1,
        OUT_DUPLICATE = 2'd2,
        OUT_EXHAUSTED = 2'd3
    } outcome_t;

    // One accepted command word.
    typedef struct packed {
        logic [2:0] command;
        field_t     reservation_id;
        field_t     intent_ordinal;
    } cmd_word_t;

    // Input stage handoff to the step logic.
    typedef struct packed {
        logic      valid;
        cmd_word_t word;
    } stage_t;

    // Architectural tracker state.
    typedef struct packed {
        logic      started;
        logic      closed;
        logic      planned;
        logic      active;
        logic      rendered;
        err_code_t sticky_error;
        count_t    loaded_count;
        count_t    head_index;
        count_t    issued_total;
        count_t    rendered_total;
        count_t    commit_total;
        field_t    serial_counter;
        field_t    active_serial;
        field_t    active_item;
    } track_state_t;

    // One result word.
    typedef struct packed {
        logic      ok;
        outcome_t  reserve_outcome;
        field_t    granted_id;
        field_t    granted_ordinal;
        err_code_t error_code;
        logic      is_started;
        logic      is_closed;
        logic      planned_end;
        logic      has_active;
        logic      active_rendered;
        field_t    committed_count;
        field_t    unissued_count;
    } result_t;

endpackage

`default_nettype wire

// ===== design/ioct_ifs.sv =====
// Valid/ready channel interfaces for the tracker: command words in, result words out.
// Depends on ioct_pkg for the field types.
`default_nettype none

interface ioct_cmd_if;
    import ioct_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] command;
    field_t     reservation_id;
    field_t     intent_ordinal;

    modport source (output valid, output command, output reservation_id,
                    output intent_ordinal, input ready);
    modport sink   (input valid, input command, input reservation_id,
                    input intent_ordinal, output ready);
endinterface

interface ioct_res_if;
    import ioct_pkg::*;

    logic       valid;
    logic       ready;
    logic       ok;
    logic [1:0] reserve_outcome;
    field_t     granted_id;
    field_t     granted_ordinal;
    logic [2:0] error_code;
    logic       is_started;
    logic       is_closed;
    logic       planned_end;
    logic       has_active;
    logic       active_rendered;
    field_t     committed_count;
    field_t     unissued_count;

    modport source (output valid, output ok, output reserve_outcome, output granted_id,
                    output granted_ordinal, output error_code, output is_started,
                    output is_closed, output planned_end, output has_active,
                    output active_rendered, output committed_count,
                    output unissued_count, input ready);
    modport sink   (input valid, input ok, input reserve_outcome, input granted_id,
                    input granted_ordinal, input error_code, input is_started,
                    input is_closed, input planned_end, input has_active,
                    input active_rendered, input committed_count,
                    input unissued_count, output ready);
endinterface

`default_nettype wire

// ===== design/ioct_in_reg.sv =====
// Input register of the tracker: captures one command word per cycle while it is empty or its held word moves on.
// Depends on ioct_pkg and the ioct_cmd_if interface.
`default_nettype none

module ioct_in_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    ioct_cmd_if.sink             cmd_chan,
    input  wire logic            advance,
    output ioct_pkg::stage_t     stage
);
    import ioct_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cmd_word_t word_reg;
    logic      take;

    // Accept when empty or when the held word moves on this cycle
    assign cmd_chan.ready = !valid_reg || advance;
    assign take           = cmd_chan.valid && cmd_chan.ready;

    // Hold, refill or drain the stage
    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg.command        <= cmd_chan.command;
            word_reg.reservation_id <= cmd_chan.reservation_id;
            word_reg.intent_ordinal <= cmd_chan.intent_ordinal;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;

endmodule

`default_nettype wire

// ===== design/ioct_step.sv =====
// Command decode and state update of the tracker: next state and result word.
// Purely combinational; depends on ioct_pkg.
`default_nettype none

module ioct_step (
    input  wire ioct_pkg::cmd_word_t    word,
    input  wire ioct_pkg::track_state_t state_cur,
    input  wire ioct_pkg::field_t       required_count,
    output ioct_pkg::track_state_t      state_nxt,
    output ioct_pkg::result_t           result
);
    import ioct_pkg::*;

    // Counter value to port field width: truncate or zero-extend
    function automatic field_t to_field(input count_t v);
        logic [COUNT_WIDTH+FIELD_WIDTH-1:0] w;
        w = {{FIELD_WIDTH{1'b0}}, v};
        return w[FIELD_WIDTH-1:0];
    endfunction

    // Field value to counter width, saturating when it does not fit
    function automatic count_t sat_count(input field_t v);
        logic [COUNT_WIDTH+FIELD_WIDTH-1:0] w;
        w = {{COUNT_WIDTH{1'b0}}, v};
        if ((w >> COUNT_WIDTH) != '0)
        begin
            return '1;
        end
        return w[COUNT_WIDTH-1:0];
    endfunction

    // Keep the first error code
    function automatic err_code_t keep_first(input err_code_t cur, input err_code_t code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

    // Counter conservation check on a candidate state
    function automatic logic cons_ok(input track_state_t s);
        logic [COUNT_WIDTH:0] head_plus;
        logic [COUNT_WIDTH:0] commit_plus;
        head_plus   = {1'b0, s.head_index} + {{COUNT_WIDTH{1'b0}}, s.active};
        commit_plus = {1'b0, s.commit_total}
                    + {{COUNT_WIDTH{1'b0}}, (s.active && s.rendered)};
        return (s.head_index == s.commit_total)
            && (s.head_index <= s.issued_total)
            && (s.issued_total <= s.loaded_count)
            && ({1'b0, s.issued_total} == head_plus)
            && ({1'b0, s.rendered_total} == commit_plus);
    endfunction

    track_state_t nxt;
    logic         ok;
    outcome_t     outcome;
    field_t       gid;
    field_t       gord;
    count_t       load_n;
    logic         names_active;
    logic         gate_fail;

    assign load_n       = sat_count(required_count);
    assign names_active = state_cur.active && (word.reservation_id != '0)
                        && (word.reservation_id == state_cur.active_serial)
                        && (word.intent_ordinal == state_cur.active_item);

    // Shared gate of reserve, render and commit: not started, closed or errored
    assign gate_fail = !state_cur.started || state_cur.closed
                     || (state_cur.sticky_error != ERR_NONE);

    // Decode the command and work out the next state
    always_comb
    begin
        nxt     = state_cur;
        ok      = 1'b0;
        outcome = OUT_NONE;
        gid     = '0;
        gord    = '0;
        unique case (word.command) inside
            CMD_START:
            begin
                nxt = '0;
                if (load_n == '0)
                begin
                    nxt.sticky_error = ERR_INVALID;
                end
                else
                begin
                    nxt.loaded_count = load_n;
                    nxt.started      = 1'b1;
                    ok               = 1'b1;
                end
            end
            CMD_RESERVE:
            begin
                if (!state_cur.started)
                begin
                    nxt.sticky_error = keep_first(state_cur.sticky_error, ERR_NOT_STARTED);
                end
                else if (state_cur.closed)
                begin
                    nxt.sticky_error = keep_first(state_cur.sticky_error, ERR_CLOSED);
                end
                else if (gate_fail)
                begin
                    nxt = state_cur;
                end
                else if (state_cur.active)
                begin
                    outcome = OUT_DUPLICATE;
                    gid     = state_cur.active_serial;
                    gord    = state_cur.active_item;
                    ok      = 1'b1;
                end
                else if (state_cur.head_index == state_cur.loaded_count)
                begin
                    outcome = OUT_EXHAUSTED;
                    ok      = 1'b1;
                end
                else
                begin
                    nxt.serial_counter = state_cur.serial_counter + field_t'(1);
                    nxt.active_serial  = state_cur.serial_counter + field_t'(1);
                    nxt.active_item    = to_field(state_cur.head_index);
                    nxt.active         = 1'b1;
                    nxt.rendered       = 1'b0;
                    nxt.issued_total   = state_cur.issued_total + count_t'(1);
                    if (!cons_ok(nxt))
                    begin
                        nxt.sticky_error = ERR_CONSERVATION;
                    end
                    else
                    begin
                        outcome = OUT_RESERVED;
                        gid     = nxt.active_serial;
                        gord    = nxt.active_item;
                        ok      = 1'b1;
                    end
                end
            end
            CMD_RENDER, CMD_COMMIT:
            begin
                if (!state_cur.started)
                begin
                    nxt.sticky_error = keep_first(state_cur.sticky_error, ERR_NOT_STARTED);
                end
                else if (state_cur.closed)
                begin
                    nxt.sticky_error = keep_first(state_cur.sticky_error, ERR_CLOSED);
                end
                else if (gate_fail)
                begin
                    nxt = state_cur;
                end
                else if (!names_active)
                begin
                    nxt.sticky_error = ERR_MISMATCH;
                end
                else if (word.command == CMD_RENDER)
                begin
                    if (state_cur.rendered)
                    begin
                        nxt.sticky_error = ERR_DUP_RENDER;
                    end
                    else
                    begin
                        nxt.rendered       = 1'b1;
                        nxt.rendered_total = state_cur.rendered_total + count_t'(1);
                        ok                 = 1'b1;
                    end
                end
                else if (!state_cur.rendered)
                begin
                    nxt.sticky_error = ERR_RENDER_MISSING;
                end
                else
                begin
                    nxt.head_index    = state_cur.head_index + count_t'(1);
                    nxt.commit_total  = state_cur.commit_total + count_t'(1);
                    nxt.active        = 1'b0;
                    nxt.rendered      = 1'b0;
                    nxt.active_serial = '0;
                    nxt.active_item   = '0;
                    if (!cons_ok(nxt))
                    begin
                        nxt.sticky_error = ERR_CONSERVATION;
                    end
                    else
                    begin
                        ok = 1'b1;
                    end
                end
            end
            CMD_CLOSE_PLANNED, CMD_CLOSE_UNPLANNED:
            begin
                if (!state_cur.started)
                begin
                    nxt.sticky_error = keep_first(state_cur.sticky_error, ERR_NOT_STARTED);
                end
                else if (state_cur.closed)
                begin
                    nxt.sticky_error = keep_first(state_cur.sticky_error, ERR_CLOSED);
                end
                else
                begin
                    nxt.planned = (word.command == CMD_CLOSE_PLANNED);
                    nxt.closed  = 1'b1;
                    if (!cons_ok(nxt))
                    begin
                        nxt.sticky_error = keep_first(state_cur.sticky_error,
                                                      ERR_CONSERVATION);
                    end
                    else
                    begin
                        ok = (state_cur.sticky_error == ERR_NONE);
                    end
                end
            end
            default:
            begin
                nxt = state_cur;
            end
        endcase
    end

    assign state_nxt = nxt;

    // Result word: command outcome plus snapshot of the updated state
    assign result.ok              = ok;
    assign result.reserve_outcome = outcome;
    assign result.granted_id      = gid;
    assign result.granted_ordinal = gord;
    assign result.error_code      = nxt.sticky_error;
    assign result.is_started      = nxt.started;
    assign result.is_closed       = nxt.closed;
    assign result.planned_end     = nxt.planned;
    assign result.has_active      = nxt.active;
    assign result.active_rendered = nxt.rendered;
    assign result.committed_count = to_field(nxt.head_index);
    assign result.unissued_count  = to_field(nxt.loaded_count - nxt.issued_total);

endmodule

`default_nettype wire

// ===== design/ioct_out_reg.sv =====
// Result register of the tracker: holds one result word until the receiver takes it.
// Depends on ioct_pkg and the ioct_res_if interface.
`default_nettype none

module ioct_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ioct_pkg::result_t result,
    output logic                   advance,
    ioct_res_if.source             res_chan
);
    import ioct_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // Free to load when empty or when the held word is taken this cycle
    assign advance = !valid_reg || res_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            result_reg <= result;
        end
    end

    // Drive the result channel
    assign res_chan.valid           = valid_reg;
    assign res_chan.ok              = result_reg.ok;
    assign res_chan.reserve_outcome = result_reg.reserve_outcome;
    assign res_chan.granted_id      = result_reg.granted_id;
    assign res_chan.granted_ordinal = result_reg.granted_ordinal;
    assign res_chan.error_code      = result_reg.error_code;
    assign res_chan.is_started      = result_reg.is_started;
    assign res_chan.is_closed       = result_reg.is_closed;
    assign res_chan.planned_end     = result_reg.planned_end;
    assign res_chan.has_active      = result_reg.has_active;
    assign res_chan.active_rendered = result_reg.active_rendered;
    assign res_chan.committed_count = result_reg.committed_count;
    assign res_chan.unissued_count  = result_reg.unissued_count;

endmodule

`default_nettype wire

// ===== design/in_order_reserve_commit_tracker_core.sv =====
// In-order reserve/commit tracker, top level.
// Usage:
//   cmd_chan carries one command word (command, reservation_id, intent_ordinal)
//   per valid/ready handshake; res_chan returns exactly one result word per
//   command, in order, with the ok flag, reserve outcome, granted id/ordinal
//   and a snapshot of the tracker state after the command.
//   cfg_we/cfg_wdata write required_count, which a start command loads; write
//   it only while no command is in flight.
// Timing:
//   An accepted word sits in the input register; once the result register is
//   free, it is decoded and committed to the tracker state at the same edge at
//   which its result is loaded into the result register and offered. One command
//   per cycle is sustained while res_chan.ready stays high; the step logic is combinational.
// Reset:
//   rst_n clears all tracker state, required_count and both stage valids.
// Stall:
//   While res_chan.ready is low the result word holds, the input register
//   fills and then cmd_chan.ready drops; nothing is lost or repeated.
// Depends on ioct_pkg, ioct_ifs, ioct_in_reg, ioct_step and ioct_out_reg.
`default_nettype none

module in_order_reserve_commit_tracker_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire ioct_pkg::field_t cfg_wdata,
    ioct_cmd_if.sink              cmd_chan,
    ioct_res_if.source            res_chan
);
    import ioct_pkg::*;

    stage_t       stage;
    logic         advance;
    logic         step_fire;
    field_t       required_count_reg;
    track_state_t state_reg;
    track_state_t state_next;
    result_t      result;

    assign step_fire = stage.valid && advance;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            required_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            required_count_reg <= cfg_wdata;
        end
    end

    // Tracker state advances with each command that moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    ioct_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_chan (cmd_chan),
        .advance  (advance),
        .stage    (stage)
    );

    ioct_step u_step (
        .word           (stage.word),
        .state_cur      (state_reg),
        .required_count (required_count_reg),
        .state_nxt      (state_next),
        .result         (result)
    );

    ioct_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (stage.valid),
        .result   (result),
        .advance  (advance),
        .res_chan (res_chan)
    );

    // A rendered mark only exists on an outstanding reservation
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.rendered |-> state_reg.active)
        else $error("rendered flag set without an active reservation");

    // An outstanding reservation only exists on a started tracker
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.active |-> state_reg.started)
        else $error("active reservation on a tracker that is not started");

    // Commits never pass the loaded count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.head_index <= state_reg.loaded_count)
        else $error("head index beyond loaded count");

    // The first error stays until a start command
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && (stage.word.command != CMD_START)
         && (state_reg.sticky_error != ERR_NONE))
        |=> $stable(state_reg.sticky_error))
        else $error("sticky error changed without a start");

endmodule

`default_nettype wire

// ===== sim/ioct_tracker_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the in-order reserve/commit tracker: watches the command and result
// channels, predicts each result word and compares it field by field.
// Depends on ioct_pkg and ioct_ifs.

module ioct_tracker_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire ioct_pkg::field_t cfg_wdata,
    ioct_cmd_if                   cmd_mon,
    ioct_res_if                   res_mon,
    output int                    mismatch_count,
    output int                    words_pending
);
    import ioct_pkg::*;

    // Shadow of required_count and of the tracker state
    field_t       shadow_count;
    track_state_t trk;

    // Results still owed by the block, oldest first
    result_t      owed_q[$];
    int           miss_total = 0;

    cmd_word_t    seen_word;
    result_t      want_word;
    result_t      got_word;

    // Keep the first error code only
    function automatic void flag_error(input err_code_t code);
        if (trk.sticky_error == ERR_NONE)
            trk.sticky_error = code;
    endfunction

    // Counter conservation: heads, issues, renders and commits must agree
    function automatic bit counters_balanced();
        int act;
        int act_r;
        act   = trk.active ? 1 : 0;
        act_r = (trk.active && trk.rendered) ? 1 : 0;
        if (trk.head_index != trk.commit_total) return 1'b0;
        if (trk.head_index > trk.issued_total) return 1'b0;
        if (trk.issued_total > trk.loaded_count) return 1'b0;
        if (int'(trk.issued_total) != int'(trk.head_index) + act) return 1'b0;
        if (int'(trk.rendered_total) != int'(trk.commit_total) + act_r) return 1'b0;
        return int'(trk.loaded_count) == int'(trk.head_index) + act
                                         + int'(trk.loaded_count) - int'(trk.issued_total);
    endfunction

    // Gate for mark rendered and commit: started, open, clean, naming the active one
    function automatic bit names_live(input field_t rid, input field_t ord);
        if (!trk.started) begin
            flag_error(ERR_NOT_STARTED);
            return 1'b0;
        end
        if (trk.closed) begin
            flag_error(ERR_CLOSED);
            return 1'b0;
        end
        if (trk.sticky_error != ERR_NONE) return 1'b0;
        if (!(trk.active && rid != '0 && rid == trk.active_serial
              && ord == trk.active_item)) begin
            flag_error(ERR_MISMATCH);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one command word to the shadow state and build its result word
    function automatic result_t tracker_step(input cmd_word_t w);
        result_t  r;
        logic     ok;
        outcome_t oc;
        field_t   gid;
        field_t   gord;
        ok   = 1'b0;
        oc   = OUT_NONE;
        gid  = '0;
        gord = '0;
        case (w.command)
            CMD_START:
            begin
                trk = '0;
                if (shadow_count == '0)
                    flag_error(ERR_INVALID);
                else
                begin
                    trk.loaded_count = shadow_count;
                    trk.started      = 1'b1;
                    ok               = 1'b1;
                end
            end
            CMD_RESERVE:
            begin
                if (!trk.started)
                    flag_error(ERR_NOT_STARTED);
                else if (trk.closed)
                    flag_error(ERR_CLOSED);
                else if (trk.sticky_error != ERR_NONE)
                begin
                end
                else if (trk.active)
                begin
                    oc   = OUT_DUPLICATE;
                    gid  = trk.active_serial;
                    gord = trk.active_item;
                    ok   = 1'b1;
                end
                else if (trk.head_index == trk.loaded_count)
                begin
                    oc = OUT_EXHAUSTED;
                    ok = 1'b1;
                end
                else
                begin
                    trk.serial_counter = trk.serial_counter + 1'b1;
                    trk.active_serial  = trk.serial_counter;
                    trk.active_item    = trk.head_index;
                    trk.active         = 1'b1;
                    trk.rendered       = 1'b0;
                    trk.issued_total   = trk.issued_total + 1'b1;
                    if (!counters_balanced())
                        flag_error(ERR_CONSERVATION);
                    else
                    begin
                        oc   = OUT_RESERVED;
                        gid  = trk.active_serial;
                        gord = trk.active_item;
                        ok   = 1'b1;
                    end
                end
            end
            CMD_RENDER:
            begin
                if (names_live(w.reservation_id, w.intent_ordinal))
                begin
                    if (trk.rendered)
                        flag_error(ERR_DUP_RENDER);
                    else
                    begin
                        trk.rendered       = 1'b1;
                        trk.rendered_total = trk.rendered_total + 1'b1;
                        ok                 = 1'b1;
                    end
                end
            end
            CMD_COMMIT:
            begin
                if (names_live(w.reservation_id, w.intent_ordinal))
                begin
                    if (!trk.rendered)
                        flag_error(ERR_RENDER_MISSING);
                    else
                    begin
                        trk.head_index    = trk.head_index + 1'b1;
                        trk.commit_total  = trk.commit_total + 1'b1;
                        trk.active        = 1'b0;
                        trk.rendered      = 1'b0;
                        trk.active_serial = '0;
                        trk.active_item   = '0;
                        if (!counters_balanced())
                            flag_error(ERR_CONSERVATION);
                        else
                            ok = 1'b1;
                    end
                end
            end
            CMD_CLOSE_PLANNED, CMD_CLOSE_UNPLANNED:
            begin
                if (!trk.started)
                    flag_error(ERR_NOT_STARTED);
                else if (trk.closed)
                    flag_error(ERR_CLOSED);
                else
                begin
                    // Close even with an error pending; ok reports it
                    trk.planned = (w.command == CMD_CLOSE_PLANNED);
                    trk.closed  = 1'b1;
                    if (!counters_balanced())
                        flag_error(ERR_CONSERVATION);
                    else
                        ok = (trk.sticky_error == ERR_NONE);
                end
            end
            default:
            begin
            end
        endcase
        r.ok              = ok;
        r.reserve_outcome = oc;
        r.granted_id      = gid;
        r.granted_ordinal = gord;
        r.error_code      = trk.sticky_error;
        r.is_started      = trk.started;
        r.is_closed       = trk.closed;
        r.planned_end     = trk.planned;
        r.has_active      = trk.active;
        r.active_rendered = trk.rendered;
        r.committed_count = trk.head_index;
        r.unissued_count  = trk.loaded_count - trk.issued_total;
        return r;
    endfunction

    // Count a mismatch; report only the first few
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            miss_total++;
            if (miss_total <= 10)
                $display("%0t: result %s mismatch: expected %0d, got %0d",
                         $realtime, name, want, got);
        end
    endtask

    task automatic compare_word(input result_t want, input result_t got);
        check_field("ok", want.ok, got.ok);
        check_field("reserve_outcome", want.reserve_outcome, got.reserve_outcome);
        check_field("granted_id", want.granted_id, got.granted_id);
        check_field("granted_ordinal", want.granted_ordinal, got.granted_ordinal);
        check_field("error_code", want.error_code, got.error_code);
        check_field("is_started", want.is_started, got.is_started);
        check_field("is_closed", want.is_closed, got.is_closed);
        check_field("planned_end", want.planned_end, got.planned_end);
        check_field("has_active", want.has_active, got.has_active);
        check_field("active_rendered", want.active_rendered, got.active_rendered);
        check_field("committed_count", want.committed_count, got.committed_count);
        check_field("unissued_count", want.unissued_count, got.unissued_count);
    endtask

    // Track register writes, queue a prediction per command word, match result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = '0;
            trk          = '0;
            owed_q.delete();
            words_pending  <= 0;
            mismatch_count <= miss_total;
        end
        else
        begin
            if (cfg_we)
                shadow_count = cfg_wdata;

            if (cmd_mon.valid && cmd_mon.ready)
            begin
                seen_word.command        = cmd_mon.command;
                seen_word.reservation_id = cmd_mon.reservation_id;
                seen_word.intent_ordinal = cmd_mon.intent_ordinal;
                want_word = tracker_step(seen_word);
                owed_q    = {owed_q, want_word};
            end

            if (res_mon.valid && res_mon.ready)
            begin
                got_word.ok              = res_mon.ok;
                got_word.reserve_outcome = outcome_t'(res_mon.reserve_outcome);
                got_word.granted_id      = res_mon.granted_id;
                got_word.granted_ordinal = res_mon.granted_ordinal;
                got_word.error_code      = err_code_t'(res_mon.error_code);
                got_word.is_started      = res_mon.is_started;
                got_word.is_closed       = res_mon.is_closed;
                got_word.planned_end     = res_mon.planned_end;
                got_word.has_active      = res_mon.has_active;
                got_word.active_rendered = res_mon.active_rendered;
                got_word.committed_count = res_mon.committed_count;
                got_word.unissued_count  = res_mon.unissued_count;
                if (owed_q.size() == 0)
                begin
                    miss_total++;
                    if (miss_total <= 10)
                        $display("%0t: result word with nothing outstanding: %h",
                                 $realtime, got_word);
                end
                else
                begin
                    want_word = owed_q.pop_front();
                    compare_word(want_word, got_word);
                end
            end

            words_pending  <= owed_q.size();
            mismatch_count <= miss_total;
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Top of the tracker testbench: clock, reset, command stimulus, result stalls, verdict.
// Depends on ioct_pkg, ioct_ifs, the tracker core and ioct_tracker_checker.

module tb;
    import ioct_pkg::*;

    // Command codes the block leaves unused
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         HOLD_CYCLES   = 60;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   cfg_we;
    field_t cfg_wdata;

    ioct_cmd_if cmd_chan();
    ioct_res_if res_chan();

    int     mismatches;
    int     pending_words;
    int     words_sent = 0;
    int     idle_pct   = 0;
    int     stall_pct  = 0;
    int     cycle_count = 0;
    int     phase_cnt[8];

    // Receiver side: random stalls plus one long hold-off
    logic   rx_ready  = 1'b0;
    logic   hold_req  = 1'b0;
    logic   hold_done;
    int     hold_left;

    assign res_chan.ready = rx_ready;

    in_order_reserve_commit_tracker_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd_chan (cmd_chan),
        .res_chan (res_chan)
    );

    ioct_tracker_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd_mon       (cmd_chan),
        .res_mon       (res_chan),
        .mismatch_count(mismatches),
        .words_pending (pending_words)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drop ready at random; hold it low for a long stretch once on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rx_ready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            rx_ready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            rx_ready <= ($urandom_range(99) >= stall_pct);
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("in_order_reserve_commit_tracker_core test failed");
            $finish;
        end
    end

    function automatic field_t any_field();
        return 16'($urandom);
    endfunction

    // Offer one command word after a random idle gap; return at the accepting edge
    task automatic send_word(input logic [2:0] code, input field_t rid, input field_t ord);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_chan.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_chan.valid          <= 1'b1;
        cmd_chan.command        <= code;
        cmd_chan.reservation_id <= rid;
        cmd_chan.intent_ordinal <= ord;
        @(posedge clk);
        while (!cmd_chan.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Pause the sender until every outstanding result word has come back
    task automatic drain_results();
        cmd_chan.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words != 0);
    endtask

    task automatic write_count(input field_t value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Directed opening: not started, zero count, each error but conservation, duplicate, exhausted, close
    task automatic directed_words();
        send_word(CMD_RESERVE, 16'hFFFF, 16'hFFFF);
        send_word(CMD_START, '0, '0);
        send_word(CMD_CLOSE_PLANNED, '0, '0);
        drain_results();
        write_count(16'd2);
        // mismatch with nothing active, then reserve and close under a sticky error
        send_word(CMD_START, '0, '0);
        send_word(CMD_RENDER, '0, '0);
        send_word(CMD_RESERVE, '0, '0);
        send_word(CMD_CLOSE_UNPLANNED, '0, '0);
        // duplicate reserve, then commit before render
        send_word(CMD_START, '0, '0);
        send_word(CMD_RESERVE, '0, '0);
        send_word(CMD_RESERVE, '0, '0);
        send_word(CMD_COMMIT, 16'd1, 16'd0);
        // render twice
        send_word(CMD_START, '0, '0);
        send_word(CMD_RESERVE, '0, '0);
        send_word(CMD_RENDER, 16'd1, 16'd0);
        send_word(CMD_RENDER, 16'd1, 16'd0);
        // full clean pass to exhaustion, planned close, then use after close
        send_word(CMD_START, '0, '0);
        send_word(CMD_RESERVE, '0, '0);
        send_word(CMD_RENDER, 16'd1, 16'd0);
        send_word(CMD_COMMIT, 16'd1, 16'd0);
        send_word(CMD_RESERVE, '0, '0);
        send_word(CMD_RENDER, 16'd2, 16'd1);
        send_word(CMD_COMMIT, 16'd2, 16'd1);
        send_word(CMD_RESERVE, '0, '0);
        send_word(CMD_CLOSE_PLANNED, '0, '0);
        send_word(CMD_RESERVE, '0, '0);
        send_word(CMD_UNUSED_LO, '0, '0);
        send_word(CMD_UNUSED_HI, 16'hFFFF, 16'hFFFF);
    endtask

    // One session: start, clean reserve/render/commit rounds, then a close,
    // a broken step or nothing
    task automatic run_session(input int count);
        int         rounds;
        int         serial;
        int         head;
        int         k;
        logic [2:0] noise_cmd;
        serial = 0;
        head   = 0;
        send_word(CMD_START, any_field(), any_field());
        rounds = $urandom_range(1, 6);
        for (k = 0; k < rounds; k++)
        begin
            if (head >= count)
                send_word(CMD_RESERVE, any_field(), any_field());
            else
            begin
                send_word(CMD_RESERVE, any_field(), any_field());
                serial++;
                if ($urandom_range(3) == 0)
                    send_word(CMD_RESERVE, '0, '0);
                // leave the reservation active now and then
                if ($urandom_range(9) == 0)
                    break;
                send_word(CMD_RENDER, field_t'(serial), field_t'(head));
                send_word(CMD_COMMIT, field_t'(serial), field_t'(head));
                head++;
            end
        end

        case ($urandom_range(9))
            0, 1, 2:
            begin
                send_word($urandom_range(1) ? CMD_CLOSE_PLANNED : CMD_CLOSE_UNPLANNED,
                          any_field(), any_field());
                if ($urandom_range(1))
                    send_word(CMD_COMMIT, field_t'(serial), field_t'(head));
            end
            3, 4, 5:
            begin
                case ($urandom_range(5))
                    0: send_word(CMD_RENDER, field_t'(serial + 1), field_t'(head));
                    1: send_word(CMD_COMMIT, field_t'(serial), field_t'(head + 1));
                    2: send_word(CMD_RENDER, '0, field_t'(head));
                    3:
                    begin
                        send_word(CMD_RESERVE, '0, '0);
                        send_word(CMD_COMMIT, field_t'(serial + 1), field_t'(head));
                    end
                    4:
                    begin
                        send_word(CMD_RESERVE, '0, '0);
                        send_word(CMD_RENDER, field_t'(serial + 1), field_t'(head));
                        send_word(CMD_RENDER, field_t'(serial + 1), field_t'(head));
                    end
                    default:
                    begin
                        noise_cmd = 3'($urandom_range(7));
                        send_word(noise_cmd, any_field(), any_field());
                    end
                endcase
                // a few more words against the error state
                repeat ($urandom_range(1, 3))
                begin
                    noise_cmd = 3'($urandom_range(1, 7));
                    send_word(noise_cmd, field_t'(serial), field_t'(head));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        int p;
        int target;
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_wdata               <= '0;
        cmd_chan.valid          <= 1'b0;
        cmd_chan.command        <= CMD_START;
        cmd_chan.reservation_id <= '0;
        cmd_chan.intent_ordinal <= '0;
        phase_cnt = '{1, 65535, 3, 0, 0, 5, 2, 0};
        phase_cnt[4] = $urandom_range(2, 9);
        phase_cnt[7] = $urandom_range(65535);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        // Phases: new count each time, idling cycles through none/sender/receiver/both
        for (p = 0; p < 8; p++)
        begin
            drain_results();
            write_count(field_t'(phase_cnt[p]));
            idle_pct = (p % 4 == 1) ? 76 : (p % 4 == 3) ? 24 : 0;
            stall_pct <= (p % 4 == 2) ? 76 : (p % 4 == 3) ? 24 : 0;
            if (p == 0)
                hold_req <= 1'b1;
            target = words_sent + ((phase_cnt[p] == 0) ? 40 : 155);
            while (words_sent < target)
            begin
                run_session(phase_cnt[p]);
                if ($urandom_range(19) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("in_order_reserve_commit_tracker_core test passed");
        else
            $display("in_order_reserve_commit_tracker_core test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ioct_pkg.sv
design/ioct_ifs.sv
design/ioct_in_reg.sv
design/ioct_step.sv
design/ioct_out_reg.sv
design/in_order_reserve_commit_tracker_core.sv
sim/ioct_tracker_checker.sv
sim/tb.sv
